@@ rtl/mfd_pkg.sv @@
`default_nettype none

package mfd_pkg;

    // field widths of one frame and one record
    localparam int FRAME_ID_W = 11;
    localparam int LEN_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int SPAN_W     = 32;
    localparam int TEMP_W     = 9;
    localparam int MODE_W     = 3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_MIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_MAX   = 3'd6;

    // register values after reset
    localparam logic [BYTE_W-1:0]        NODE_ID_RST      = 8'd1;
    localparam logic signed [SPAN_W-1:0] POSITION_MIN_RST = -32'sd819200;
    localparam logic signed [SPAN_W-1:0] POSITION_MAX_RST = 32'sd819200;
    localparam logic signed [SPAN_W-1:0] VELOCITY_MIN_RST = -32'sd3276800;
    localparam logic signed [SPAN_W-1:0] VELOCITY_MAX_RST = 32'sd3276800;
    localparam logic signed [SPAN_W-1:0] TORQUE_MIN_RST   = -32'sd1179648;
    localparam logic signed [SPAN_W-1:0] TORQUE_MAX_RST   = 32'sd1179648;

    // saturation bounds of a scaled value
    localparam logic signed [SPAN_W-1:0] SPAN_MIN_VAL = 32'sh8000_0000;
    localparam logic signed [SPAN_W-1:0] SPAN_MAX_VAL = 32'sh7fff_ffff;

    // frame length thresholds
    localparam logic [LEN_W-1:0] MIN_LEN   = 4'd6;
    localparam logic [LEN_W-1:0] TEMP_LEN  = 4'd7;
    localparam logic [LEN_W-1:0] FAULT_LEN = 4'd8;

    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 9'sd40;

    // identifier groups, identifier bits 10..4
    localparam int ID_GRP_W = 7;
    localparam logic [ID_GRP_W-1:0] ID_GRP_IMPEDANCE = 7'h00;
    localparam logic [ID_GRP_W-1:0] ID_GRP_POSITION  = 7'h10;
    localparam logic [ID_GRP_W-1:0] ID_GRP_VELOCITY  = 7'h20;
    localparam logic [ID_GRP_W-1:0] ID_GRP_CURRENT   = 7'h30;

    // control modes
    localparam logic [MODE_W-1:0] MODE_IMPEDANCE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POSITION  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_VELOCITY  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CURRENT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UNKNOWN   = 3'd4;

    // record fields that bypass the scalers
    typedef struct packed {
        logic                     accepted;
        logic signed [TEMP_W-1:0] temperature;
        logic                     temperature_present;
        logic [BYTE_W-1:0]        fault_bits;
        logic                     fault_present;
        logic [MODE_W-1:0]        mode;
    } t_side;

endpackage

`default_nettype wire

@@ rtl/mfd_in_if.sv @@
`default_nettype none

interface mfd_in_if;
    import mfd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FRAME_ID_W-1:0] frame_id;
    logic [LEN_W-1:0]      frame_length;
    logic [BYTE_W-1:0]     byte0;
    logic [BYTE_W-1:0]     byte1;
    logic [BYTE_W-1:0]     byte2;
    logic [BYTE_W-1:0]     byte3;
    logic [BYTE_W-1:0]     byte4;
    logic [BYTE_W-1:0]     byte5;
    logic [BYTE_W-1:0]     byte6;
    logic [BYTE_W-1:0]     byte7;

    modport source (
        output valid, frame_id, frame_length,
        output byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
        input  ready
    );

    modport sink (
        input  valid, frame_id, frame_length,
        input  byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/mfd_out_if.sv @@
`default_nettype none

interface mfd_out_if;
    import mfd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic signed [SPAN_W-1:0] position;
    logic signed [SPAN_W-1:0] velocity;
    logic signed [SPAN_W-1:0] torque;
    logic signed [TEMP_W-1:0] temperature;
    logic                     temperature_present;
    logic [BYTE_W-1:0]        fault_bits;
    logic                     fault_present;
    logic [MODE_W-1:0]        mode;

    modport source (
        output valid, accepted, position, velocity, torque, temperature,
        output temperature_present, fault_bits, fault_present, mode,
        input  ready
    );

    modport sink (
        input  valid, accepted, position, velocity, torque, temperature,
        input  temperature_present, fault_bits, fault_present, mode,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/mfd_scale.sv @@
`default_nettype none

// min + trunc(raw * (max - min) / (2^RAW_BITS - 1)), saturated to 32 bits
// stages: span magnitude, product, folded quotient, corrected quotient
module mfd_scale #(
    parameter int RAW_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [RAW_BITS-1:0]              i_raw,
    input  logic signed [mfd_pkg::SPAN_W-1:0] i_min,
    input  logic signed [mfd_pkg::SPAN_W-1:0] i_max,
    output logic signed [mfd_pkg::SPAN_W-1:0] o_value
);
    import mfd_pkg::*;

    localparam int DW = SPAN_W + 1;                        // span difference
    localparam int PW = RAW_BITS + DW;                     // product
    localparam int K  = (PW + RAW_BITS - 1) / RAW_BITS;    // fold terms + 1
    localparam int HW = 4;                                 // remainder headroom
    localparam int RW = RAW_BITS + HW;                     // remainder
    localparam int VW = SPAN_W + 3;                        // unsaturated sum
    localparam logic [RAW_BITS:0] DEN = {1'b0, {RAW_BITS{1'b1}}};

    logic [DW-1:0]       diff;
    logic [DW-1:0]       mag;
    logic                neg;

    logic [RAW_BITS-1:0] r_raw;
    logic [DW-1:0]       r_mag;
    logic                r_neg_a;
    logic [PW-1:0]       r_prod;
    logic                r_neg_b;
    logic [DW-1:0]       r_q0;
    logic [RW-1:0]       r_xlo;
    logic                r_neg_c;
    logic [DW-1:0]       r_q;
    logic                r_neg_d;

    logic [DW-1:0]       n_q0;
    logic [RW-1:0]       rem;
    logic [HW-1:0]       c0;
    logic [RAW_BITS:0]   r2;
    logic [HW:0]         corr;
    logic [DW-1:0]       n_q;

    logic [VW-1:0]       q_ext;
    logic [VW-1:0]       val;
    logic                in_range;

    // span difference as sign and magnitude
    assign diff = {i_max[SPAN_W-1], i_max} - {i_min[SPAN_W-1], i_min};
    assign neg  = diff[DW-1];
    assign mag  = neg ? (~diff + DW'(1)) : diff;

    // x / (2^b - 1) ~ sum of x >> kb, low by at most K
    always_comb begin
        n_q0 = '0;
        for (int k = 1; k < K; k++) begin
            n_q0 = n_q0 + DW'(r_prod >> (k * RAW_BITS));
        end
    end

    // remainder is small, so its low bits suffice for the correction
    always_comb begin
        rem  = r_xlo - {r_q0[HW-1:0], {RAW_BITS{1'b0}}} + r_q0[RW-1:0];
        c0   = rem[RW-1:RAW_BITS];
        r2   = {1'b0, rem[RAW_BITS-1:0]} + (RAW_BITS + 1)'(c0);
        corr = (HW + 1)'(c0) + (HW + 1)'(r2 >= DEN);
        n_q  = r_q0 + DW'(corr);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_raw   <= i_raw;
            r_mag   <= mag;
            r_neg_a <= neg;
            r_prod  <= PW'(r_raw) * PW'(r_mag);
            r_neg_b <= r_neg_a;
            r_q0    <= n_q0;
            r_xlo   <= r_prod[RW-1:0];
            r_neg_c <= r_neg_b;
            r_q     <= n_q;
            r_neg_d <= r_neg_c;
        end
    end

    // apply sign, add offset, saturate
    assign q_ext    = {{(VW - DW){1'b0}}, r_q};
    assign val      = {{(VW - SPAN_W){i_min[SPAN_W-1]}}, i_min}
                    + (r_neg_d ? (~q_ext + VW'(1)) : q_ext);
    assign in_range = (&val[VW-1:SPAN_W-1]) | ~(|val[VW-1:SPAN_W-1]);
    assign o_value  = in_range ? $signed(val[SPAN_W-1:0])
                    : (val[VW-1] ? SPAN_MIN_VAL : SPAN_MAX_VAL);

endmodule

`default_nettype wire

@@ rtl/motor_feedback_frame_decoder.sv @@
`default_nettype none

// channel   dir   handshake      payload
// i_in      in    valid/ready    frame_id, frame_length, byte0..byte7
// o_out     out   valid/ready    accepted, position, velocity, torque,
//                                temperature(+present), fault_bits(+present), mode
// i_cfg     in    write enable   i_cfg_idx, i_cfg_data (no read-back)
//
// one word per cycle in and out unless the output stalls; the output word passes
// through five register stages after the edge that takes the frame: span, multiply,
// fold, correct, output
// synchronous active-low reset clears valid flags and loads register defaults
// the whole pipeline advances together; it stalls only when the output word
// is held and not taken, and bubbles pass through without cost
module motor_feedback_frame_decoder #(
    parameter int POSITION_RAW_BITS = 16,
    parameter int SMALL_RAW_BITS    = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mfd_in_if.sink                            i_in,
    mfd_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mfd_pkg::SPAN_W-1:0]        i_cfg_data
);
    import mfd_pkg::*;

    localparam int STAGES = 4;

    // configuration registers
    logic [BYTE_W-1:0]        r_node_id;
    logic signed [SPAN_W-1:0] r_position_min;
    logic signed [SPAN_W-1:0] r_position_max;
    logic signed [SPAN_W-1:0] r_velocity_min;
    logic signed [SPAN_W-1:0] r_velocity_max;
    logic signed [SPAN_W-1:0] r_torque_min;
    logic signed [SPAN_W-1:0] r_torque_max;

    // pipeline control and side fields
    logic [STAGES-1:0]        r_vld;
    t_side                    r_side [STAGES];
    logic                     r_out_valid;
    logic                     adv;

    t_side                    n_side;

    // raw codes from the packed data bytes
    logic [15:0]                  pos_word;
    logic [11:0]                  vel_word;
    logic [11:0]                  cur_word;
    logic [POSITION_RAW_BITS-1:0] pos_raw;
    logic [SMALL_RAW_BITS-1:0]    vel_raw;
    logic [SMALL_RAW_BITS-1:0]    cur_raw;

    logic signed [SPAN_W-1:0] pos_val;
    logic signed [SPAN_W-1:0] vel_val;
    logic signed [SPAN_W-1:0] trq_val;

    // output register
    logic                     r_accepted;
    logic signed [SPAN_W-1:0] r_position;
    logic signed [SPAN_W-1:0] r_velocity;
    logic signed [SPAN_W-1:0] r_torque;
    logic signed [TEMP_W-1:0] r_temperature;
    logic                     r_temperature_present;
    logic [BYTE_W-1:0]        r_fault_bits;
    logic                     r_fault_present;
    logic [MODE_W-1:0]        r_mode;

    // everything moves when the output register is free or being emptied
    assign adv        = ~r_out_valid | o_out.ready;
    assign i_in.ready = adv;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id      <= NODE_ID_RST;
            r_position_min <= POSITION_MIN_RST;
            r_position_max <= POSITION_MAX_RST;
            r_velocity_min <= VELOCITY_MIN_RST;
            r_velocity_max <= VELOCITY_MAX_RST;
            r_torque_min   <= TORQUE_MIN_RST;
            r_torque_max   <= TORQUE_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NODE_ID:      r_node_id      <= i_cfg_data[BYTE_W-1:0];
                CFG_POSITION_MIN: r_position_min <= $signed(i_cfg_data);
                CFG_POSITION_MAX: r_position_max <= $signed(i_cfg_data);
                CFG_VELOCITY_MIN: r_velocity_min <= $signed(i_cfg_data);
                CFG_VELOCITY_MAX: r_velocity_max <= $signed(i_cfg_data);
                CFG_TORQUE_MIN:   r_torque_min   <= $signed(i_cfg_data);
                CFG_TORQUE_MAX:   r_torque_max   <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // field unpack: position 16 bits, velocity and current 12 bits each;
    // narrower codes keep the top bits of the packed field
    assign pos_word = {i_in.byte1, i_in.byte2};
    assign vel_word = {i_in.byte3, i_in.byte4[7:4]};
    assign cur_word = {i_in.byte4[3:0], i_in.byte5};
    assign pos_raw  = pos_word[15 -: POSITION_RAW_BITS];
    assign vel_raw  = vel_word[11 -: SMALL_RAW_BITS];
    assign cur_raw  = cur_word[11 -: SMALL_RAW_BITS];

    // acceptance, temperature, fault flags and mode; all zero on reject
    always_comb begin
        n_side = '0;
        if (i_in.frame_length >= MIN_LEN && i_in.byte0 == r_node_id) begin
            n_side.accepted = 1'b1;
            if (i_in.frame_length >= TEMP_LEN) begin
                n_side.temperature         = $signed({1'b0, i_in.byte6}) - TEMP_OFFSET;
                n_side.temperature_present = 1'b1;
            end
            if (i_in.frame_length >= FAULT_LEN) begin
                n_side.fault_bits    = i_in.byte7;
                n_side.fault_present = 1'b1;
            end
            // only identifiers 0xN00..0xN0F with N from 0 to 3 map to a known mode
            unique case (i_in.frame_id[FRAME_ID_W-1:4])
                ID_GRP_IMPEDANCE: n_side.mode = MODE_IMPEDANCE;
                ID_GRP_POSITION:  n_side.mode = MODE_POSITION;
                ID_GRP_VELOCITY:  n_side.mode = MODE_VELOCITY;
                ID_GRP_CURRENT:   n_side.mode = MODE_CURRENT;
                default:          n_side.mode = MODE_UNKNOWN;
            endcase
        end
    end

    // three scalers in lock step with the side-field pipe
    mfd_scale #(.RAW_BITS(POSITION_RAW_BITS)) u_pos_scale (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_raw   (pos_raw),
        .i_min   (r_position_min),
        .i_max   (r_position_max),
        .o_value (pos_val)
    );

    mfd_scale #(.RAW_BITS(SMALL_RAW_BITS)) u_vel_scale (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_raw   (vel_raw),
        .i_min   (r_velocity_min),
        .i_max   (r_velocity_max),
        .o_value (vel_val)
    );

    mfd_scale #(.RAW_BITS(SMALL_RAW_BITS)) u_trq_scale (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_raw   (cur_raw),
        .i_min   (r_torque_min),
        .i_max   (r_torque_max),
        .o_value (trq_val)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld       <= {r_vld[STAGES-2:0], i_in.valid};
            r_out_valid <= r_vld[STAGES-1];
        end
    end

    // side fields and output word
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= n_side;
            for (int s = 1; s < STAGES; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_accepted            <= r_side[STAGES-1].accepted;
            r_position            <= r_side[STAGES-1].accepted ? pos_val : '0;
            r_velocity            <= r_side[STAGES-1].accepted ? vel_val : '0;
            r_torque              <= r_side[STAGES-1].accepted ? trq_val : '0;
            r_temperature         <= r_side[STAGES-1].temperature;
            r_temperature_present <= r_side[STAGES-1].temperature_present;
            r_fault_bits          <= r_side[STAGES-1].fault_bits;
            r_fault_present       <= r_side[STAGES-1].fault_present;
            r_mode                <= r_side[STAGES-1].mode;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.accepted            = r_accepted;
    assign o_out.position            = r_position;
    assign o_out.velocity            = r_velocity;
    assign o_out.torque              = r_torque;
    assign o_out.temperature         = r_temperature;
    assign o_out.temperature_present = r_temperature_present;
    assign o_out.fault_bits          = r_fault_bits;
    assign o_out.fault_present       = r_fault_present;
    assign o_out.mode                = r_mode;

    // a rejected frame gives an all-zero word
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_accepted) |->
            (r_position == '0 && r_velocity == '0 && r_torque == '0 &&
             r_mode == '0 && !r_temperature_present && !r_fault_present))
        else $error("rejected frame gave non-zero fields");

    // fault flags only come with a full frame
    a_fault_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fault_present) |-> (r_temperature_present && r_accepted))
        else $error("fault flags without temperature or acceptance");

    // a taken word enters the first stage
    a_take_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted word lost at first stage");

    // the pipe holds still while the output word waits
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> $stable(r_vld))
        else $error("pipeline moved during output stall");

endmodule

`default_nettype wire
